[design/cls_pkg.sv]
// Shared constants and types for the current loop input scaler.
package cls_pkg;

    localparam int SAMPLE_W      = 10;
    localparam int ENG_W         = 16;
    localparam int NUM_CH        = 3;
    localparam int NUM_STAGES    = 6;
    localparam int ADDR_W        = 5;
    localparam int DATA_W        = 32;
    localparam int AVG_DEPTH_DEF = 4;

    localparam logic [SAMPLE_W-1:0] CNT_4MA  = 10'd205;
    localparam logic [SAMPLE_W-1:0] CNT_20MA = 10'd1000;
    localparam int                  SPAN_DIV = 795;

    typedef enum logic [2:0] {
        REG_LOW_CH1  = 3'd0,
        REG_HIGH_CH1 = 3'd1,
        REG_LOW_CH2  = 3'd2,
        REG_HIGH_CH2 = 3'd3,
        REG_LOW_CH3  = 3'd4,
        REG_HIGH_CH3 = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic ld_in;
        logic ld_avg;
        logic ld_mul;
        logic ld_part;
        logic ld_quot;
        logic ld_out;
        logic drop_oldest;
        logic use_avg;
    } pipe_ctrl_t;

endpackage

[design/cls_regs.sv]
// Register file for the scaling end points, written and read over the APB port.
module cls_regs
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [cls_pkg::ADDR_W-1:0]                  paddr,
    input  logic [cls_pkg::DATA_W-1:0]                  pwdata,
    output logic [cls_pkg::DATA_W-1:0]                  prdata,
    output logic                                        pready,
    output logic [cls_pkg::NUM_CH-1:0][cls_pkg::ENG_W-1:0] scale_low,
    output logic [cls_pkg::NUM_CH-1:0][cls_pkg::ENG_W-1:0] scale_high
);

    logic [5:0][cls_pkg::ENG_W-1:0] scale_reg;
    cls_pkg::reg_idx_t              reg_idx;
    logic                           wr_en;
    logic [cls_pkg::ENG_W-1:0]      rd_val;
    logic                           rd_hit;

    assign reg_idx = cls_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                cls_pkg::REG_LOW_CH1:  scale_reg[cls_pkg::REG_LOW_CH1]  <= pwdata[15:0];
                cls_pkg::REG_HIGH_CH1: scale_reg[cls_pkg::REG_HIGH_CH1] <= pwdata[15:0];
                cls_pkg::REG_LOW_CH2:  scale_reg[cls_pkg::REG_LOW_CH2]  <= pwdata[15:0];
                cls_pkg::REG_HIGH_CH2: scale_reg[cls_pkg::REG_HIGH_CH2] <= pwdata[15:0];
                cls_pkg::REG_LOW_CH3:  scale_reg[cls_pkg::REG_LOW_CH3]  <= pwdata[15:0];
                cls_pkg::REG_HIGH_CH3: scale_reg[cls_pkg::REG_HIGH_CH3] <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        rd_val = '0;
        rd_hit = 1'b1;
        unique case (reg_idx)
            cls_pkg::REG_LOW_CH1:  rd_val = scale_reg[cls_pkg::REG_LOW_CH1];
            cls_pkg::REG_HIGH_CH1: rd_val = scale_reg[cls_pkg::REG_HIGH_CH1];
            cls_pkg::REG_LOW_CH2:  rd_val = scale_reg[cls_pkg::REG_LOW_CH2];
            cls_pkg::REG_HIGH_CH2: rd_val = scale_reg[cls_pkg::REG_HIGH_CH2];
            cls_pkg::REG_LOW_CH3:  rd_val = scale_reg[cls_pkg::REG_LOW_CH3];
            cls_pkg::REG_HIGH_CH3: rd_val = scale_reg[cls_pkg::REG_HIGH_CH3];
            default:               rd_hit = 1'b0;
        endcase
        prdata = rd_hit ? {{(cls_pkg::DATA_W - cls_pkg::ENG_W){rd_val[cls_pkg::ENG_W-1]}}, rd_val}
                        : '0;
    end

    assign scale_low[0]  = scale_reg[cls_pkg::REG_LOW_CH1];
    assign scale_high[0] = scale_reg[cls_pkg::REG_HIGH_CH1];
    assign scale_low[1]  = scale_reg[cls_pkg::REG_LOW_CH2];
    assign scale_high[1] = scale_reg[cls_pkg::REG_HIGH_CH2];
    assign scale_low[2]  = scale_reg[cls_pkg::REG_LOW_CH3];
    assign scale_high[2] = scale_reg[cls_pkg::REG_HIGH_CH3];

endmodule

[design/cls_avg.sv]
// Sample history, running sum and averaging divider for one channel.
module cls_avg
#(
    parameter int AVG_DEPTH = cls_pkg::AVG_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cls_pkg::pipe_ctrl_t           ctrl,
    input  logic [cls_pkg::SAMPLE_W-1:0]  sample,
    output logic [cls_pkg::SAMPLE_W-1:0]  avg
);

    localparam int  LOG_D    = $clog2(AVG_DEPTH);
    localparam int  SUM_W    = cls_pkg::SAMPLE_W + LOG_D;
    localparam int  RECIP_SH = SUM_W + LOG_D;
    localparam int  RECIP_W  = RECIP_SH;
    localparam int  PROD_W   = SUM_W + RECIP_W;
    localparam longint RECIP_L = ((64'd1 << RECIP_SH) + AVG_DEPTH - 1) / AVG_DEPTH;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    logic [AVG_DEPTH-1:0][cls_pkg::SAMPLE_W-1:0] ring_reg;
    logic [SUM_W-1:0]                            sum_reg;
    logic [SUM_W-1:0]                            sum_next;
    logic [SUM_W-1:0]                            a_sum_reg;
    logic [cls_pkg::SAMPLE_W-1:0]                a_raw_reg;
    logic                                        a_use_avg_reg;
    logic [PROD_W-1:0]                           quot_full;
    logic [cls_pkg::SAMPLE_W-1:0]                avg_next;
    logic [cls_pkg::SAMPLE_W-1:0]                avg_reg;

    // The oldest sample only leaves the sum once every slot holds a real sample.
    assign sum_next = sum_reg + SUM_W'(sample)
                    - (ctrl.drop_oldest ? SUM_W'(ring_reg[AVG_DEPTH-1]) : SUM_W'(0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.ld_in)
        begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_in)
        begin
            ring_reg      <= {ring_reg[AVG_DEPTH-2:0], sample};
            a_sum_reg     <= sum_next;
            a_raw_reg     <= sample;
            a_use_avg_reg <= ctrl.use_avg;
        end
    end

    // Division by the depth as a multiplication by its rounded-up reciprocal.
    assign quot_full = PROD_W'(a_sum_reg) * PROD_W'(RECIP);
    assign avg_next  = a_use_avg_reg ? quot_full[RECIP_SH +: cls_pkg::SAMPLE_W] : a_raw_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_avg)
        begin
            avg_reg <= avg_next;
        end
    end

    assign avg = avg_reg;

endmodule

[design/cls_scale.sv]
// Clamping and linear scaling of one averaged count to engineering units.
module cls_scale
(
    input  logic                                 clk,
    input  cls_pkg::pipe_ctrl_t                  ctrl,
    input  logic [cls_pkg::SAMPLE_W-1:0]         avg_in,
    input  logic [cls_pkg::ENG_W-1:0]            scale_low,
    input  logic [cls_pkg::ENG_W-1:0]            scale_high,
    output logic [cls_pkg::SAMPLE_W-1:0]         avg_out,
    output logic [cls_pkg::ENG_W-1:0]            eng
);

    localparam int MAG_W   = cls_pkg::SAMPLE_W + cls_pkg::ENG_W;
    localparam int SPLIT   = MAG_W / 2;
    localparam int DIV_LOG = $clog2(cls_pkg::SPAN_DIV);
    localparam int DIV_SH  = MAG_W + DIV_LOG;
    localparam int RECIP_W = MAG_W + 1;
    localparam int PP_W    = (MAG_W - SPLIT) + RECIP_W;
    localparam int TOT_W   = MAG_W + RECIP_W;
    localparam longint RECIP_L = ((64'd1 << DIV_SH) + cls_pkg::SPAN_DIV - 1) / cls_pkg::SPAN_DIV;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int EXT_W = cls_pkg::ENG_W + 1;

    // Span and offset stage.
    logic [EXT_W-1:0]              low_x;
    logic [EXT_W-1:0]              high_x;
    logic [EXT_W-1:0]              diff_hl;
    logic [EXT_W-1:0]              diff_lh;
    logic                          span_neg;
    logic [cls_pkg::ENG_W-1:0]     span_abs;
    logic [cls_pkg::SAMPLE_W-1:0]  cnt_off;
    logic                          clamp_lo;
    logic                          clamp_hi;

    logic [MAG_W-1:0]              c_mag_reg;
    logic [cls_pkg::ENG_W-1:0]     c_base_reg;
    logic                          c_clamp_reg;
    logic                          c_neg_reg;
    logic [cls_pkg::SAMPLE_W-1:0]  c_avg_reg;

    logic [PP_W-1:0]               d_pp_lo_reg;
    logic [PP_W-1:0]               d_pp_hi_reg;
    logic [cls_pkg::ENG_W-1:0]     d_base_reg;
    logic                          d_clamp_reg;
    logic                          d_neg_reg;
    logic [cls_pkg::SAMPLE_W-1:0]  d_avg_reg;

    logic [TOT_W-1:0]              total;
    logic [cls_pkg::ENG_W-1:0]     e_quot_reg;
    logic [cls_pkg::ENG_W-1:0]     e_base_reg;
    logic                          e_clamp_reg;
    logic                          e_neg_reg;
    logic [cls_pkg::SAMPLE_W-1:0]  e_avg_reg;

    logic [EXT_W-1:0]              quot_s;
    logic [EXT_W-1:0]              eng_sum;
    logic [cls_pkg::ENG_W-1:0]     eng_next;
    logic [cls_pkg::ENG_W-1:0]     eng_reg;
    logic [cls_pkg::SAMPLE_W-1:0]  avg_reg;

    assign low_x    = {scale_low[cls_pkg::ENG_W-1], scale_low};
    assign high_x   = {scale_high[cls_pkg::ENG_W-1], scale_high};
    assign diff_hl  = high_x - low_x;
    assign diff_lh  = low_x - high_x;
    assign span_neg = diff_hl[EXT_W-1];
    assign span_abs = span_neg ? diff_lh[cls_pkg::ENG_W-1:0] : diff_hl[cls_pkg::ENG_W-1:0];
    assign cnt_off  = avg_in - cls_pkg::CNT_4MA;
    assign clamp_lo = (avg_in <= cls_pkg::CNT_4MA);
    assign clamp_hi = (avg_in >= cls_pkg::CNT_20MA);

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_mul)
        begin
            c_mag_reg   <= MAG_W'(cnt_off) * MAG_W'(span_abs);
            c_base_reg  <= clamp_hi ? scale_high : scale_low;
            c_clamp_reg <= clamp_lo || clamp_hi;
            c_neg_reg   <= span_neg;
            c_avg_reg   <= avg_in;
        end
    end

    // The divide by the span of counts is a reciprocal multiply, split in two halves.
    always_ff @(posedge clk)
    begin
        if (ctrl.ld_part)
        begin
            d_pp_lo_reg <= PP_W'(c_mag_reg[SPLIT-1:0]) * PP_W'(RECIP);
            d_pp_hi_reg <= PP_W'(c_mag_reg[MAG_W-1:SPLIT]) * PP_W'(RECIP);
            d_base_reg  <= c_base_reg;
            d_clamp_reg <= c_clamp_reg;
            d_neg_reg   <= c_neg_reg;
            d_avg_reg   <= c_avg_reg;
        end
    end

    assign total = (TOT_W'(d_pp_hi_reg) << SPLIT) + TOT_W'(d_pp_lo_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_quot)
        begin
            e_quot_reg  <= total[DIV_SH +: cls_pkg::ENG_W];
            e_base_reg  <= d_base_reg;
            e_clamp_reg <= d_clamp_reg;
            e_neg_reg   <= d_neg_reg;
            e_avg_reg   <= d_avg_reg;
        end
    end

    // The magnitude was divided, so applying the sign afterwards truncates toward zero.
    assign quot_s   = e_neg_reg ? (EXT_W'(0) - EXT_W'(e_quot_reg)) : EXT_W'(e_quot_reg);
    assign eng_sum  = {e_base_reg[cls_pkg::ENG_W-1], e_base_reg} + quot_s;
    assign eng_next = e_clamp_reg ? e_base_reg : eng_sum[cls_pkg::ENG_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_out)
        begin
            eng_reg <= eng_next;
            avg_reg <= e_avg_reg;
        end
    end

    assign eng     = eng_reg;
    assign avg_out = avg_reg;

endmodule

[design/current_loop_input_scaler_core.sv]
// Top level of the three-channel 4-20 mA input scaler.
// Each request carries one converter count per channel and produces exactly one result
// holding the averaged count and the scaled engineering value of every channel. A new
// request can be taken every clock cycle unless sample_stall is high. Between a request
// and its result lie the six register stages of the pipeline: history and running sum,
// the averaging divide, the span multiply, the two partial products of the reciprocal
// multiply that divides by 795, their sum, and the final offset and clamp. While results
// are stalled, requests are still taken until all six stages hold an item. The end points
// must be written over the APB port only while no request is in flight; the block itself
// does not enforce this.
module current_loop_input_scaler_core
#(
    parameter int AVG_DEPTH = cls_pkg::AVG_DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cls_pkg::ADDR_W-1:0]          paddr,
    input  logic [cls_pkg::DATA_W-1:0]          pwdata,
    output logic [cls_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic [cls_pkg::SAMPLE_W-1:0]        sample_ch1,
    input  logic [cls_pkg::SAMPLE_W-1:0]        sample_ch2,
    input  logic [cls_pkg::SAMPLE_W-1:0]        sample_ch3,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [cls_pkg::SAMPLE_W-1:0]        avg_ch1,
    output logic [cls_pkg::SAMPLE_W-1:0]        avg_ch2,
    output logic [cls_pkg::SAMPLE_W-1:0]        avg_ch3,
    output logic [cls_pkg::ENG_W-1:0]           eng_ch1,
    output logic [cls_pkg::ENG_W-1:0]           eng_ch2,
    output logic [cls_pkg::ENG_W-1:0]           eng_ch3
);

    localparam int SLOT_W = $clog2(AVG_DEPTH);
    localparam int NS     = cls_pkg::NUM_STAGES;

    logic [SLOT_W-1:0]                                slot_reg;
    logic [SLOT_W-1:0]                                slot_next;
    logic                                             filled_reg;
    logic                                             filled_next;
    logic                                             slot_wrap;
    logic [NS-1:0]                                    v_reg;
    logic [NS-1:0]                                    v_next;
    logic [NS-1:0]                                    free;
    logic [NS-1:0]                                    src_valid;
    logic                                             accept;
    cls_pkg::pipe_ctrl_t                              ctrl;

    logic [cls_pkg::NUM_CH-1:0][cls_pkg::ENG_W-1:0]    scale_low;
    logic [cls_pkg::NUM_CH-1:0][cls_pkg::ENG_W-1:0]    scale_high;
    logic [cls_pkg::NUM_CH-1:0][cls_pkg::SAMPLE_W-1:0] sample_w;
    logic [cls_pkg::NUM_CH-1:0][cls_pkg::SAMPLE_W-1:0] avg_mid;
    logic [cls_pkg::NUM_CH-1:0][cls_pkg::SAMPLE_W-1:0] avg_w;
    logic [cls_pkg::NUM_CH-1:0][cls_pkg::ENG_W-1:0]    eng_w;

    cls_regs u_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .scale_low  (scale_low),
        .scale_high (scale_high)
    );

    // A stage can load when it is empty or its content moves on in the same cycle.
    always_comb
    begin
        src_valid = {v_reg[NS-2:0], sample_valid};
        free[NS-1] = !v_reg[NS-1] || !result_stall;
        for (int i = NS - 2; i >= 0; i--)
        begin
            free[i] = !v_reg[i] || free[i+1];
        end
        for (int i = 0; i < NS; i++)
        begin
            v_next[i] = free[i] ? src_valid[i] : v_reg[i];
        end
    end

    assign accept       = sample_valid && free[0];
    assign sample_stall = !free[0];
    assign result_valid = v_reg[NS-1];

    assign slot_wrap   = (slot_reg == SLOT_W'(AVG_DEPTH - 1));
    assign slot_next   = slot_wrap ? '0 : slot_reg + SLOT_W'(1);
    assign filled_next = filled_reg || slot_wrap;

    always_comb
    begin
        ctrl.ld_in       = accept;
        ctrl.ld_avg      = src_valid[1] && free[1];
        ctrl.ld_mul      = src_valid[2] && free[2];
        ctrl.ld_part     = src_valid[3] && free[3];
        ctrl.ld_quot     = src_valid[4] && free[4];
        ctrl.ld_out      = src_valid[5] && free[5];
        ctrl.drop_oldest = filled_reg;
        ctrl.use_avg     = filled_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg      <= '0;
            slot_reg   <= '0;
            filled_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
            if (accept)
            begin
                slot_reg   <= slot_next;
                filled_reg <= filled_next;
            end
        end
    end

    assign sample_w[0] = sample_ch1;
    assign sample_w[1] = sample_ch2;
    assign sample_w[2] = sample_ch3;

    for (genvar ch = 0; ch < cls_pkg::NUM_CH; ch++)
    begin : g_ch
        cls_avg #(.AVG_DEPTH(AVG_DEPTH)) u_avg
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .sample (sample_w[ch]),
            .avg    (avg_mid[ch])
        );

        cls_scale u_scale
        (
            .clk        (clk),
            .ctrl       (ctrl),
            .avg_in     (avg_mid[ch]),
            .scale_low  (scale_low[ch]),
            .scale_high (scale_high[ch]),
            .avg_out    (avg_w[ch]),
            .eng        (eng_w[ch])
        );
    end

    assign avg_ch1 = avg_w[0];
    assign avg_ch2 = avg_w[1];
    assign avg_ch3 = avg_w[2];
    assign eng_ch1 = eng_w[0];
    assign eng_ch2 = eng_w[1];
    assign eng_ch3 = eng_w[2];

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (&v_reg))
        else $error("Request stalled while a pipeline stage was empty.");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_W'(AVG_DEPTH - 1))
        else $error("Write slot beyond the history depth.");

    a_fill_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (filled_reg && !$past(filled_reg)) |-> (slot_reg == '0))
        else $error("History marked full without the write slot wrapping.");

    a_load_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ld_out |=> result_valid)
        else $error("Output stage loaded but no result shown.");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the three-channel current loop input scaler core.
module tb_top;

    localparam int SAMPLE_W        = cls_pkg::SAMPLE_W;
    localparam int ENG_W           = cls_pkg::ENG_W;
    localparam int NUM_CH          = cls_pkg::NUM_CH;
    localparam int ADDR_W          = cls_pkg::ADDR_W;
    localparam int DATA_W          = cls_pkg::DATA_W;
    localparam int AVG_DEPTH       = cls_pkg::AVG_DEPTH_DEF;
    localparam int SCALE_REG_COUNT = 6;
    localparam int DIRECTED_LEN    = 20;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_SETS      = 250;
    localparam int LONG_HOLD       = 60;
    localparam int SETTLE_CYCLES   = cls_pkg::NUM_STAGES + 4;
    localparam int MAX_PRINTED     = 30;

    typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] sample_set_t;

    typedef struct packed {
        logic [NUM_CH-1:0][SAMPLE_W-1:0] avg;
        logic [NUM_CH-1:0][ENG_W-1:0]    eng;
    } reading_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [ADDR_W-1:0]   paddr        = '0;
    logic [DATA_W-1:0]   pwdata       = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                sample_valid = 1'b0;
    logic                sample_stall;
    logic [SAMPLE_W-1:0] sample_ch1   = '0;
    logic [SAMPLE_W-1:0] sample_ch2   = '0;
    logic [SAMPLE_W-1:0] sample_ch3   = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [SAMPLE_W-1:0] avg_ch1;
    logic [SAMPLE_W-1:0] avg_ch2;
    logic [SAMPLE_W-1:0] avg_ch3;
    logic [ENG_W-1:0]    eng_ch1;
    logic [ENG_W-1:0]    eng_ch2;
    logic [ENG_W-1:0]    eng_ch3;

    sample_set_t pending_sets [$];
    reading_t    expected_readings [$];

    logic [SAMPLE_W-1:0]     history [NUM_CH][AVG_DEPTH];
    int                      history_slot = 0;
    logic                    history_full = 1'b0;
    logic signed [ENG_W-1:0] scale_cfg [SCALE_REG_COUNT] = '{default: '0};

    int drift_level [NUM_CH] = '{512, 205, 1000};

    int dir_ch1 [DIRECTED_LEN] = '{0, 1023, 205, 1000, 206, 206, 206, 206, 999, 999,
                                   999, 999, 1001, 1001, 1001, 1001, 204, 204, 204, 204};
    int dir_ch2 [DIRECTED_LEN] = '{1023, 0, 1000, 205, 999, 999, 999, 999, 206, 206,
                                   206, 206, 204, 204, 204, 204, 1023, 1023, 1023, 1023};
    int dir_ch3 [DIRECTED_LEN] = '{205, 206, 999, 1000, 0, 0, 0, 0, 1023, 1023,
                                   1023, 1023, 512, 512, 512, 512, 1000, 1000, 1000, 1000};

    logic        req_taken         = 1'b0;
    sample_set_t next_set;
    int          send_gap          = 0;
    int          stall_left        = 0;
    int          send_mode         = 0;
    int          recv_mode         = 0;
    int          long_holds_asked  = 0;
    int          long_holds_done   = 0;

    int mismatch_count  = 0;
    int requests_sent   = 0;
    int readings_seen   = 0;
    int settings_used   = 0;
    int input_stalls    = 0;
    int at_low_end      = 0;
    int at_high_end     = 0;
    int in_span         = 0;

    current_loop_input_scaler_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_ch1   (sample_ch1),
        .sample_ch2   (sample_ch2),
        .sample_ch3   (sample_ch3),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .avg_ch1      (avg_ch1),
        .avg_ch2      (avg_ch2),
        .avg_ch3      (avg_ch3),
        .eng_ch1      (eng_ch1),
        .eng_ch2      (eng_ch2),
        .eng_ch3      (eng_ch3)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    function automatic int idle_len(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return (r < 70) ? 0 : $urandom_range(1, 3);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [ENG_W-1:0] to_units(input logic [SAMPLE_W-1:0] cnt,
                                                  input logic signed [ENG_W-1:0] lo,
                                                  input logic signed [ENG_W-1:0] hi);
        int num;
        if (cnt <= cls_pkg::CNT_4MA)
            return lo;
        if (cnt >= cls_pkg::CNT_20MA)
            return hi;
        num = (int'(cnt) - int'(cls_pkg::CNT_4MA)) * (int'(hi) - int'(lo));
        return ENG_W'(int'(lo) + num / cls_pkg::SPAN_DIV);
    endfunction

    task automatic predict_reading(input sample_set_t s);
        reading_t r;
        int       ch;
        int       k;
        int       sum;
        for (ch = 0; ch < NUM_CH; ch++)
            history[ch][history_slot] = s[ch];
        history_slot++;
        if (history_slot == AVG_DEPTH)
        begin
            history_slot = 0;
            history_full = 1'b1;
        end
        for (ch = 0; ch < NUM_CH; ch++)
        begin
            if (history_full)
            begin
                sum = 0;
                for (k = 0; k < AVG_DEPTH; k++)
                    sum += history[ch][k];
                r.avg[ch] = SAMPLE_W'(sum / AVG_DEPTH);
            end
            else
                r.avg[ch] = s[ch];
            r.eng[ch] = to_units(r.avg[ch], scale_cfg[2 * ch + cls_pkg::REG_LOW_CH1],
                                 scale_cfg[2 * ch + cls_pkg::REG_HIGH_CH1]);
            if (r.avg[ch] <= cls_pkg::CNT_4MA)
                at_low_end++;
            else if (r.avg[ch] >= cls_pkg::CNT_20MA)
                at_high_end++;
            else
                in_span++;
        end
        expected_readings.push_back(r);
    endtask

    task automatic compare_reading(input reading_t got);
        reading_t want;
        int       ch;
        if (expected_readings.size() == 0)
        begin
            report_mismatch("result with no request outstanding, avg_ch1", got.avg[0], -1);
            return;
        end
        want = expected_readings.pop_front();
        for (ch = 0; ch < NUM_CH; ch++)
        begin
            if (got.avg[ch] !== want.avg[ch])
                report_mismatch($sformatf("avg_ch%0d", ch + 1), got.avg[ch], want.avg[ch]);
            if (got.eng[ch] !== want.eng[ch])
                report_mismatch($sformatf("eng_ch%0d", ch + 1),
                                $signed(got.eng[ch]), $signed(want.eng[ch]));
        end
    endtask

    always @(posedge clk)
    begin
        req_taken = rst_n && sample_valid && !sample_stall;
        if (rst_n && sample_valid && sample_stall)
            input_stalls++;
        if (req_taken)
        begin
            requests_sent++;
            predict_reading({sample_ch3, sample_ch2, sample_ch1});
        end
        if (rst_n && result_valid && !result_stall)
        begin
            readings_seen++;
            compare_reading({avg_ch3, avg_ch2, avg_ch1, eng_ch3, eng_ch2, eng_ch1});
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            sample_valid <= 1'b0;
        else if (!sample_valid || req_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                sample_valid <= 1'b0;
            end
            else if (pending_sets.size() != 0)
            begin
                next_set = pending_sets.pop_front();
                sample_ch1 <= next_set[0];
                sample_ch2 <= next_set[1];
                sample_ch3 <= next_set[2];
                sample_valid <= 1'b1;
                send_gap = idle_len(send_mode);
            end
            else
                sample_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (long_holds_done != long_holds_asked)
        begin
            long_holds_done = long_holds_asked;
            stall_left = LONG_HOLD - 1;
            result_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            stall_left = idle_len(recv_mode);
            result_stall <= 1'b0;
        end
    end

    task automatic write_scale(input int idx, input logic [ENG_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * idx);
        pwdata  <= {{(DATA_W - ENG_W){value[ENG_W-1]}}, value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx < SCALE_REG_COUNT)
            scale_cfg[idx] = value;
        @(negedge clk);
        penable <= 1'b0;
        if (idx < SCALE_REG_COUNT)
        begin
            pwrite <= 1'b0;
            @(negedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            if (prdata[ENG_W-1:0] !== value)
                report_mismatch($sformatf("read back of register %0d", idx),
                                $signed(prdata[ENG_W-1:0]), $signed(value));
            @(negedge clk);
            penable <= 1'b0;
        end
        psel <= 1'b0;
    endtask

    task automatic apply_scales(input logic [ENG_W-1:0] lo1, input logic [ENG_W-1:0] hi1,
                                input logic [ENG_W-1:0] lo2, input logic [ENG_W-1:0] hi2,
                                input logic [ENG_W-1:0] lo3, input logic [ENG_W-1:0] hi3);
        write_scale(cls_pkg::REG_LOW_CH1, lo1);
        write_scale(cls_pkg::REG_HIGH_CH1, hi1);
        write_scale(cls_pkg::REG_LOW_CH2, lo2);
        write_scale(cls_pkg::REG_HIGH_CH2, hi2);
        write_scale(cls_pkg::REG_LOW_CH3, lo3);
        write_scale(cls_pkg::REG_HIGH_CH3, hi3);
        settings_used++;
    endtask

    function automatic logic [ENG_W-1:0] pick_end_point();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3)
            return 16'h8000;
        if (r < 6)
            return 16'h7FFF;
        if (r < 8)
            return '0;
        return ENG_W'($urandom());
    endfunction

    task automatic apply_random_scales();
        logic [ENG_W-1:0] lo;
        logic [ENG_W-1:0] hi;
        int               ch;
        for (ch = 0; ch < NUM_CH; ch++)
        begin
            lo = pick_end_point();
            hi = ($urandom_range(0, 6) == 0) ? lo : pick_end_point();
            write_scale(2 * ch + cls_pkg::REG_LOW_CH1, lo);
            write_scale(2 * ch + cls_pkg::REG_HIGH_CH1, hi);
        end
        settings_used++;
    endtask

    function automatic int pick_level();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return $urandom_range(0, 1023);
        if (r < 5)
            return $urandom_range(195, 215);
        if (r < 7)
            return $urandom_range(990, 1023);
        if (r == 7)
            return 0;
        if (r == 8)
            return 1023;
        return $urandom_range(500, 700);
    endfunction

    task automatic gen_sample_set(output sample_set_t s);
        int ch;
        int v;
        for (ch = 0; ch < NUM_CH; ch++)
        begin
            if ($urandom_range(0, 19) == 0)
                drift_level[ch] = pick_level();
            if ($urandom_range(0, 9) == 0)
                v = $urandom_range(0, 1023);
            else
                v = drift_level[ch] + int'($urandom_range(0, 8)) - 4;
            if (v < 0)
                v = 0;
            if (v > 1023)
                v = 1023;
            s[ch] = SAMPLE_W'(v);
        end
    endtask

    task automatic wait_until_drained();
        while (!(pending_sets.size() == 0 && !sample_valid && expected_readings.size() == 0))
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        sample_set_t s;
        int          p;
        int          n;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        apply_scales(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'd1234, 16'd1234);
        write_scale(SCALE_REG_COUNT, 16'h7FFF);
        write_scale(SCALE_REG_COUNT + 1, 16'h8000);
        for (n = 0; n < DIRECTED_LEN; n++)
            pending_sets.push_back({SAMPLE_W'(dir_ch3[n]), SAMPLE_W'(dir_ch2[n]),
                                    SAMPLE_W'(dir_ch1[n])});
        wait_until_drained();

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 1)
                apply_scales(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
            else if (p == 2)
                apply_scales(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
            else
                apply_random_scales();
            send_mode = p % 3;
            recv_mode = (p + 1) % 3;
            for (n = 0; n < PHASE_SETS; n++)
            begin
                gen_sample_set(s);
                pending_sets.push_back(s);
            end
            if (p == 1 || p == 4)
                long_holds_asked++;
            wait_until_drained();
        end

        $display("Checked %0d results from %0d requests over %0d scale settings.",
                 readings_seen, requests_sent, settings_used);
        $display("Channel counts: %0d at 4 mA or below, %0d at 20 mA or above, %0d between;",
                 at_low_end, at_high_end, in_span);
        $display("%0d cycles with a request held back.", input_stalls);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #16000000;
        $display("Run did not finish in time.");
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[current_loop_input_scaler_core.f]
design/cls_pkg.sv
design/cls_regs.sv
design/cls_avg.sv
design/cls_scale.sv
design/current_loop_input_scaler_core.sv
tb/tb_top.sv
